>>> hw/rtl/aie_pkg.sv
// Package for the A32 instruction encoder: opcode codes, field widths
// and the fixed bit patterns of each instruction class. No dependencies.
package aie_pkg;

  localparam int unsigned OpW    = 4;
  localparam int unsigned RegW   = 4;
  localparam int unsigned CondW  = 4;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ListW  = 16;
  localparam int unsigned InDataW = 128;

  typedef enum logic [OpW-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MOV_IMM = 4'd2,
    OP_MVN_IMM = 4'd3,
    OP_MOV_REG = 4'd4,
    OP_MOVW    = 4'd5,
    OP_MOVT    = 4'd6,
    OP_LDR     = 4'd7,
    OP_B       = 4'd8,
    OP_BL      = 4'd9,
    OP_BLX_IMM = 4'd10,
    OP_BLX_REG = 4'd11,
    OP_BX      = 4'd12,
    OP_PUSH    = 4'd13,
    OP_POP     = 4'd14,
    OP_SVC     = 4'd15
  } opcode_t;

  localparam logic [CondW-1:0] COND_AL     = 4'hE;
  localparam logic [7:0]       DP_ADD_IMM  = 8'h28;
  localparam logic [7:0]       DP_SUB_IMM  = 8'h24;
  localparam logic [7:0]       DP_MOV_IMM  = 8'h3A;
  localparam logic [7:0]       DP_MVN_IMM  = 8'h3E;
  localparam logic [7:0]       DP_MOV_REG  = 8'h1A;
  localparam logic [7:0]       DP_MOVW     = 8'h30;
  localparam logic [7:0]       DP_MOVT     = 8'h34;
  localparam logic [3:0]       LDR_HI      = 4'b0101;
  localparam logic [2:0]       LDR_MID     = 3'b001;
  localparam logic [3:0]       PC_REG      = 4'hF;
  localparam logic [3:0]       BR_B        = 4'b1010;
  localparam logic [3:0]       BR_BL       = 4'b1011;
  localparam logic [6:0]       BLX_IMM_HI  = 7'b1111101;
  localparam logic [23:0]      BLX_REG_MID = 24'h12FFF3;
  localparam logic [23:0]      BX_MID      = 24'h12FFF1;
  localparam logic [11:0]      PUSH_MID    = 12'h92D;
  localparam logic [11:0]      POP_MID     = 12'h8BD;
  localparam logic [3:0]       SVC_MID     = 4'hF;
  localparam logic [WordW-1:0] BR_BIAS     = 32'd8;

endpackage

>>> hw/rtl/arm_instruction_encoder.sv
// Top level of the A32 instruction encoder: three register stages.
// Depends on aie_pkg.
//
// Takes one instruction request per beat and returns one 32-bit A32 word per beat.
// Three register stages (branch offset, immediate fixup, word assembly); a
// request passes through them in order; one request can be taken every cycle
// unless the output stalls. Each stage holds its beat while the stage after it
// is full and stalled, so backpressure on the output loses and repeats nothing.
module arm_instruction_encoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // condition[3:0], dest_reg[7:4], source_reg[11:8], immediate_value[43:12],
  // reg_mask[59:44], target_address[91:60], pc_address[123:92], zero[127:124]
  input  logic [aie_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode[3:0]
  input  logic [aie_pkg::OpW-1:0]      s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // machine_word[31:0]
  output logic [aie_pkg::WordW-1:0]    m_axis_tdata
);

  logic                          v1, v2, v3;
  logic                          rdy1, rdy2, rdy3;

  aie_pkg::opcode_t              op1, op2;
  logic [aie_pkg::CondW-1:0]     cond1, cond2;
  logic [aie_pkg::RegW-1:0]      rd1, rd2, rs1, rs2;
  logic [aie_pkg::WordW-1:0]     imm1;
  logic [aie_pkg::ListW-1:0]     list1, list2;
  logic [aie_pkg::WordW-1:0]     off1;
  logic [aie_pkg::WordW-1:0]     off_next;

  logic [23:0]                   imm24_2;
  logic [11:0]                   imm12_2, imm12_next;
  logic                          flip2, flip_next;
  logic [24:0]                   off2;

  logic [aie_pkg::WordW-1:0]     word3, word_next;
  logic [aie_pkg::WordW-1:0]     neg1;
  logic                          up1;

  assign rdy3 = !v3 || m_axis_tready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  assign off_next = s_axis_tdata[91:60] - s_axis_tdata[123:92] - aie_pkg::BR_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_axis_tvalid;
    end
    if (rdy1 && s_axis_tvalid) begin
      op1   <= aie_pkg::opcode_t'(s_axis_tuser);
      cond1 <= s_axis_tdata[3:0];
      rd1   <= s_axis_tdata[7:4];
      rs1   <= s_axis_tdata[11:8];
      imm1  <= s_axis_tdata[43:12];
      list1 <= s_axis_tdata[59:44];
      off1  <= off_next;
    end
  end

  assign neg1 = '0 - imm1;
  assign up1  = !imm1[31] && (imm1 != '0);

  always_comb begin
    imm12_next = imm1[11:0];
    flip_next  = imm1[31];
    unique case (op1) inside
      aie_pkg::OP_ADD, aie_pkg::OP_SUB: begin
        imm12_next = imm1[31] ? neg1[11:0] : imm1[11:0];
      end
      aie_pkg::OP_MOV_IMM, aie_pkg::OP_MVN_IMM: begin
        imm12_next = imm1[31] ? ~imm1[11:0] : imm1[11:0];
      end
      aie_pkg::OP_LDR: begin
        imm12_next = up1 ? imm1[11:0] : neg1[11:0];
        flip_next  = up1;
      end
      default: begin
        imm12_next = imm1[11:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      op2     <= op1;
      cond2   <= cond1;
      rd2     <= rd1;
      rs2     <= rs1;
      list2   <= list1;
      imm24_2 <= imm1[23:0];
      imm12_2 <= imm12_next;
      flip2   <= flip_next;
      off2    <= off1[25:1];
    end
  end

  always_comb begin
    word_next = '0;
    unique case (op2) inside
      aie_pkg::OP_ADD, aie_pkg::OP_SUB: begin
        word_next = {aie_pkg::COND_AL,
                     ((op2 == aie_pkg::OP_SUB) ^ flip2) ? aie_pkg::DP_SUB_IMM
                                                        : aie_pkg::DP_ADD_IMM,
                     rs2, rd2, imm12_2};
      end
      aie_pkg::OP_MOV_IMM, aie_pkg::OP_MVN_IMM: begin
        word_next = {aie_pkg::COND_AL,
                     ((op2 == aie_pkg::OP_MVN_IMM) ^ flip2) ? aie_pkg::DP_MVN_IMM
                                                            : aie_pkg::DP_MOV_IMM,
                     4'h0, rd2, imm12_2};
      end
      aie_pkg::OP_MOV_REG: begin
        word_next = {aie_pkg::COND_AL, aie_pkg::DP_MOV_REG, 4'h0, rd2, 8'h00, rs2};
      end
      aie_pkg::OP_MOVW: begin
        word_next = {aie_pkg::COND_AL, aie_pkg::DP_MOVW, imm24_2[15:12], rd2, imm12_2};
      end
      aie_pkg::OP_MOVT: begin
        word_next = {aie_pkg::COND_AL, aie_pkg::DP_MOVT, imm24_2[15:12], rd2, imm12_2};
      end
      aie_pkg::OP_LDR: begin
        word_next = {aie_pkg::COND_AL, aie_pkg::LDR_HI, flip2, aie_pkg::LDR_MID,
                     aie_pkg::PC_REG, rd2, imm12_2};
      end
      aie_pkg::OP_B: begin
        word_next = {cond2, aie_pkg::BR_B, off2[24:1]};
      end
      aie_pkg::OP_BL: begin
        word_next = {cond2, aie_pkg::BR_BL, off2[24:1]};
      end
      aie_pkg::OP_BLX_IMM: begin
        word_next = {aie_pkg::BLX_IMM_HI, off2[0], off2[24:1]};
      end
      aie_pkg::OP_BLX_REG: begin
        word_next = {cond2, aie_pkg::BLX_REG_MID, rs2};
      end
      aie_pkg::OP_BX: begin
        word_next = {cond2, aie_pkg::BX_MID, rs2};
      end
      aie_pkg::OP_PUSH: begin
        word_next = {cond2, aie_pkg::PUSH_MID, list2};
      end
      aie_pkg::OP_POP: begin
        word_next = {cond2, aie_pkg::POP_MID, list2};
      end
      aie_pkg::OP_SVC: begin
        word_next = {aie_pkg::COND_AL, aie_pkg::SVC_MID, imm24_2};
      end
      default: begin
        word_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      word3 <= word_next;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = word3;

endmodule
